>>> design/tasp_pkg.sv
// Shared types and constants for the three-axis step pulse generator.
`default_nettype none
package tasp_pkg;
    localparam int unsigned TicksPerUs = 32;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QAW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned QCW = $clog2(QueueDepth + 1);
    localparam int unsigned NumAxes = 3;
    localparam logic [31:0] HI_WORD_MASK = 32'hFFFF0000;
    localparam logic [31:0] LO_WORD_MASK = 32'h0000FFFF;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_KILL = 2'd2,
        CMD_TERMINATE = 2'd3
    } t_cmd;

    // One queued move.
    typedef struct packed {
        logic [31:0] steps_x;
        logic [31:0] steps_y;
        logic [31:0] steps_z;
        logic [31:0] duration;
    } t_move;

    // Beat from the front part to the back part.
    typedef struct packed {
        t_cmd cmd;
        logic accepted;
        logic [QCW-1:0] level;
        logic load;
        t_move move;
    } t_job;

    // Normalized timing for one axis.
    typedef struct packed {
        logic [31:0] mag;
        logic [15:0] period;
        logic [16:0] post;
    } t_arm;
endpackage
`default_nettype wire

>>> design/three_axis_step_pulse_generator_top.sv
// Top level of the three-axis step pulse generator.
//  channel | direction | handshake
//  cmd     | in        | i_valid / o_stall
//  result  | out       | o_valid / i_stall
//  config  | in        | i_cfg_we (polarity)
// A tick, kill or terminate beat passes the back part's wait, decode and output
// states before its result is registered; no next beat is accepted before the back part takes the job.
// A beat that loads a move runs one 64-bit division plus normalization per
// nonzero axis, one axis after another on the shared divider.
// Reset is synchronous; the queue needs no clearing pass.
// One beat is in work at a time; o_stall is high until the back part has
// produced its result, and a stalled result holds back the next beat's work.
`default_nettype none
module three_axis_step_pulse_generator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic signed [31:0] i_steps_x_in,
    input  wire logic signed [31:0] i_steps_y_in,
    input  wire logic signed [31:0] i_steps_z_in,
    input  wire logic [31:0] i_duration_us,
    output logic o_valid,
    input  wire logic i_stall,
    output logic [2:0] o_step_pulses,
    output logic [2:0] o_direction_bits,
    output logic [2:0] o_motor_enables,
    output logic [2:0] o_active_mask,
    output logic o_move_accepted,
    output logic [2:0] o_queue_level,
    input  wire logic i_cfg_we,
    input  wire logic [2:0] i_cfg_data
);
    logic [2:0] r_pol;
    logic w_jv, w_take, w_pop;
    tasp_pkg::t_job w_job;

    // Polarity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pol <= '0;
        else if (i_cfg_we) r_pol <= i_cfg_data;
    end

    tasp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_steps_x_in(i_steps_x_in),
        .i_steps_y_in(i_steps_y_in), .i_steps_z_in(i_steps_z_in),
        .i_duration_us(i_duration_us), .i_pop(w_pop),
        .o_job_valid(w_jv), .i_job_take(w_take), .o_job(w_job)
    );

    tasp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_polarity(r_pol),
        .i_job_valid(w_jv), .o_job_take(w_take), .i_job(w_job), .o_pop(w_pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_step_pulses(o_step_pulses),
        .o_direction_bits(o_direction_bits), .o_motor_enables(o_motor_enables),
        .o_active_mask(o_active_mask), .o_move_accepted(o_move_accepted),
        .o_queue_level(o_queue_level)
    );

    // Motors of active axes stay enabled.
    a_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_active_mask & ~o_motor_enables) == 3'd0) else $error("active axis disabled");
    // A pulse only from an axis that is active or whose motor is disabled.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_step_pulses & ~(o_active_mask | ~o_motor_enables)) == 3'd0)
        else $error("pulse on idle axis");
    // No result while the front holds no beat.
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("result without beat");
endmodule
`default_nettype wire

>>> design/tasp_front.sv
// Front part: command decode and the move queue.
`default_nettype none
module tasp_front (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [31:0] i_steps_x_in,
    input  wire logic [31:0] i_steps_y_in,
    input  wire logic [31:0] i_steps_z_in,
    input  wire logic [31:0] i_duration_us,
    input  wire logic i_pop,
    output logic o_job_valid,
    input  wire logic i_job_take,
    output tasp_pkg::t_job o_job
);
    tasp_pkg::t_move r_mem [tasp_pkg::QueueDepth];
    logic [tasp_pkg::QAW-1:0] r_head;
    logic [tasp_pkg::QCW-1:0] r_count;
    logic r_job_valid;
    tasp_pkg::t_job r_job;
    logic w_acc, w_room, w_wr;
    logic [tasp_pkg::QCW-1:0] w_cnt;
    logic [tasp_pkg::QAW-1:0] w_slot;

    // One job in flight; the back part decides after the command if a move loads.
    assign o_stall = r_job_valid;
    assign w_acc = i_valid && !r_job_valid;
    assign w_room = (r_count < tasp_pkg::QCW'(tasp_pkg::QueueDepth));
    assign w_wr = w_acc && (tasp_pkg::t_cmd'(i_command) == tasp_pkg::CMD_ENQUEUE) && w_room;
    assign w_slot = tasp_pkg::QAW'((32'(r_head) + 32'(r_count)) % tasp_pkg::QueueDepth);

    // Queue count after the command, before a possible load.
    always_comb begin
        w_cnt = r_count;
        case (tasp_pkg::t_cmd'(i_command))
            tasp_pkg::CMD_ENQUEUE: if (w_room) w_cnt = r_count + 1'b1;
            tasp_pkg::CMD_KILL, tasp_pkg::CMD_TERMINATE: w_cnt = '0;
            default: w_cnt = r_count;
        endcase
    end

    // An enqueue into an empty queue hands the written entry on directly.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_slot] <= {i_steps_x_in, i_steps_y_in, i_steps_z_in, i_duration_us};
        if (w_acc) begin
            r_job.cmd <= tasp_pkg::t_cmd'(i_command);
            r_job.accepted <= w_wr;
            r_job.load <= (w_cnt != '0);
            r_job.level <= w_cnt;
            r_job.move <= (w_wr && (w_slot == r_head)) ?
                {i_steps_x_in, i_steps_y_in, i_steps_z_in, i_duration_us} : r_mem[r_head];
        end
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_job_valid <= 1'b1;
                r_count <= w_cnt;
            end else begin
                if (i_pop) begin
                    r_head <= tasp_pkg::QAW'((32'(r_head) + 1) % tasp_pkg::QueueDepth);
                    r_count <= r_count - 1'b1;
                end
                if (i_job_take) r_job_valid <= 1'b0;
            end
        end
    end
    always_comb begin
        o_job = r_job;
    end
    assign o_job_valid = r_job_valid;
endmodule
`default_nettype wire

>>> design/tasp_div.sv
// Iterative 64-by-32 divider with saturation and 16-bit normalization.
`default_nettype none
module tasp_div (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic o_done,
    output logic [15:0] o_period,
    output logic [16:0] o_post
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_NORM} t_state;
    t_state r_state;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0] r_cnt;
    logic [31:0] r_iv;
    logic [16:0] r_post;
    logic r_done;
    logic [32:0] w_sh;

    assign w_sh = {r_rem[31:0], r_q[63]};

    // Restoring division one bit a cycle, then one shift a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_q <= i_num;
                        r_rem <= '0;
                        r_den <= i_den;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_done <= 1'b0;
                    if (w_sh >= {1'b0, r_den}) begin
                        r_rem <= w_sh - {1'b0, r_den};
                        r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_q <= {r_q[62:0], 1'b0};
                    end
                    r_post <= 17'd1;
                    if (r_cnt == 6'd63) begin
                        r_cnt <= 6'd0;
                        r_iv <= '0;
                        r_state <= S_NORM;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_NORM: begin
                    if (r_iv == '0 && r_post == 17'd1 && r_cnt == 6'd0) begin
                        r_done <= 1'b0;
                        r_iv <= (r_q[63:32] != '0) ? 32'hFFFFFFFF : r_q[31:0];
                        r_cnt <= 6'd1;
                    end else if ((r_iv & tasp_pkg::HI_WORD_MASK) != '0) begin
                        r_done <= 1'b0;
                        r_iv <= r_iv >> 1;
                        r_post <= r_post << 1;
                    end else begin
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_done <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
    assign o_done = r_done;
    assign o_period = (r_iv[15:0] == '0) ? 16'd1 : r_iv[15:0];
    assign o_post = r_post;
endmodule
`default_nettype wire

>>> design/tasp_back.sv
// Back part: per-axis step timing, move arming and the output register.
`default_nettype none
module tasp_back (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [2:0] i_polarity,
    input  wire logic i_job_valid,
    output logic o_job_take,
    input  tasp_pkg::t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  wire logic i_stall,
    output logic [2:0] o_step_pulses,
    output logic [2:0] o_direction_bits,
    output logic [2:0] o_motor_enables,
    output logic [2:0] o_active_mask,
    output logic o_move_accepted,
    output logic [2:0] o_queue_level
);
    typedef enum logic [1:0] {S_WAIT, S_DEC, S_ARM, S_OUT} t_state;
    t_state r_state;
    logic [31:0] r_steps [tasp_pkg::NumAxes];
    logic [15:0] r_per [tasp_pkg::NumAxes];
    logic [15:0] r_pcnt [tasp_pkg::NumAxes];
    logic [16:0] r_prl [tasp_pkg::NumAxes];
    logic [16:0] r_pscnt [tasp_pkg::NumAxes];
    logic [2:0] r_active, r_dir, r_en, r_pulse;
    logic [1:0] r_axis;
    logic r_busy, r_valid, r_take, r_pop, r_loaded;
    logic [63:0] r_total;
    logic [31:0] w_raw, w_mag;
    logic w_done;
    logic [15:0] w_period;
    logic [16:0] w_post;
    logic [15:0] w_pc [tasp_pkg::NumAxes];
    logic [16:0] w_ps [tasp_pkg::NumAxes];
    logic [2:0] w_wrap, w_fire;

    assign w_raw = (r_axis == 2'd0) ? i_job.move.steps_x :
                   (r_axis == 2'd1) ? i_job.move.steps_y : i_job.move.steps_z;
    assign w_mag = w_raw[31] ? (32'd0 - w_raw) : w_raw;

    tasp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_ARM && !r_busy && w_mag != '0),
        .i_num(r_total), .i_den(w_mag),
        .o_done(w_done), .o_period(w_period), .o_post(w_post)
    );

    // Period and postscale arithmetic of one tick for each axis.
    always_comb begin
        for (int k = 0; k < tasp_pkg::NumAxes; k++) begin
            w_pc[k] = r_pcnt[k] + 1'b1;
            w_ps[k] = r_pscnt[k] - 1'b1;
            w_wrap[k] = r_active[k] && (w_pc[k] >= r_per[k]);
            w_fire[k] = w_wrap[k] && (w_ps[k] == '0);
        end
    end

    // Takes a job once the previous result has left.
    assign o_pop = r_pop;
    assign o_job_take = r_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_active <= '0;
            r_dir <= '0;
            r_en <= '0;
            r_valid <= 1'b0;
            r_busy <= 1'b0;
            r_take <= 1'b0;
            r_pop <= 1'b0;
            r_loaded <= 1'b0;
            for (int k = 0; k < tasp_pkg::NumAxes; k++) begin
                r_steps[k] <= '0;
                r_per[k] <= 16'd1;
                r_pcnt[k] <= '0;
                r_prl[k] <= 17'd1;
                r_pscnt[k] <= 17'd1;
            end
        end else begin
            r_take <= (r_state == S_OUT);
            r_valid <= (r_state == S_OUT) || (r_valid && i_stall);
            r_pop <= (r_state == S_DEC) && (r_active == '0) && i_job.load;
            case (r_state)
                S_WAIT: if (i_job_valid && !r_take && !r_valid) begin
                    case (i_job.cmd)
                        tasp_pkg::CMD_TICK: begin
                            r_pulse <= w_fire;
                            for (int k = 0; k < tasp_pkg::NumAxes; k++) begin
                                if (r_active[k]) begin
                                    if (!w_wrap[k]) begin
                                        r_pcnt[k] <= w_pc[k];
                                    end else begin
                                        r_pcnt[k] <= '0;
                                        if (!w_fire[k]) begin
                                            r_pscnt[k] <= w_ps[k];
                                        end else begin
                                            r_steps[k] <= r_steps[k] - 1'b1;
                                            r_pscnt[k] <= r_prl[k];
                                            if (r_steps[k] == 32'd1) begin
                                                r_active[k] <= 1'b0;
                                                r_en[k] <= 1'b0;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        tasp_pkg::CMD_KILL: begin
                            r_pulse <= '0;
                            r_active <= '0;
                        end
                        default: begin
                            r_pulse <= '0;
                            r_active <= r_active;
                        end
                    endcase
                    r_state <= S_DEC;
                    r_axis <= '0;
                    r_total <= 64'(i_job.move.duration) * 64'(tasp_pkg::TicksPerUs);
                end
                // A waiting move loads once every axis has gone idle.
                S_DEC: begin
                    if (r_active == '0 && i_job.load) begin
                        r_loaded <= 1'b1;
                        r_state <= S_ARM;
                    end else begin
                        r_loaded <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_ARM: begin
                    if (!r_busy) begin
                        if (r_axis == 2'd0) r_active <= '0;
                        r_dir[r_axis] <= w_raw[31] ^ i_polarity[r_axis];
                        if (w_mag != '0) r_busy <= 1'b1;
                        else if (r_axis == 2'd2) r_state <= S_OUT;
                        else r_axis <= r_axis + 1'b1;
                    end else if (w_done) begin
                        r_busy <= 1'b0;
                        r_steps[r_axis] <= w_mag;
                        r_per[r_axis] <= w_period;
                        r_pcnt[r_axis] <= '0;
                        r_prl[r_axis] <= w_post;
                        r_pscnt[r_axis] <= w_post;
                        r_active[r_axis] <= 1'b1;
                        r_en[r_axis] <= 1'b1;
                        if (r_axis == 2'd2) r_state <= S_OUT;
                        else r_axis <= r_axis + 1'b1;
                    end
                end
                S_OUT: begin
                    o_move_accepted <= i_job.accepted;
                    o_queue_level <= 3'(r_loaded ? i_job.level - 1'b1 : i_job.level);
                    r_state <= S_WAIT;
                end
                default: r_state <= S_WAIT;
            endcase
        end
    end
    assign o_valid = r_valid;
    assign o_step_pulses = r_pulse;
    assign o_direction_bits = r_dir;
    assign o_motor_enables = r_en;
    assign o_active_mask = r_active;
endmodule
`default_nettype wire
